[sv/b64_pkg.sv]
// Shared types, constants and the alphabet lookup for the base64 stream encoder.
// Used by the front, queue, back and top-level modules; depends on nothing else.
`default_nettype none

package b64_pkg;

  // Width of one raw byte and of one output character.
  localparam int unsigned ByteW = 8;

  // Groups per output line: 76 characters at four characters per group.
  localparam int unsigned GroupsPerLine = 19;
  localparam int unsigned GroupCntW     = 5;

  // Default depth of the group queue between front and back.
  localparam int unsigned QueueDepthDef = 2;

  // Fixed characters.
  localparam logic [ByteW-1:0] CharPad     = 8'h3d;  // '='
  localparam logic [ByteW-1:0] CharNewline = 8'h0a;  // line feed

  // Position of the next character within a group; newline first when present.
  typedef enum logic [2:0] {
    POS_NEWLINE = 3'd0,
    POS_C0      = 3'd1,
    POS_C1      = 3'd2,
    POS_C2      = 3'd3,
    POS_C3      = 3'd4
  } b64_pos_t;

  // One group handed from the front to the back. Missing bytes are zero.
  typedef struct packed {
    logic [3*ByteW-1:0] bytes;    // first byte in the top bits
    logic [1:0]         nbytes;   // 1, 2 or 3 real bytes
    logic               newline;  // send a line feed ahead of the group
    logic               last;     // group closes the message
  } b64_group_t;

  // Standard base64 alphabet: A-Z, a-z, 0-9, '+', '/'.
  function automatic logic [ByteW-1:0] b64_symbol(input logic [5:0] v);
    logic [ByteW-1:0] r;
    r = '0;
    if (v < 6'd26) begin
      r = 8'h41 + {2'b00, v};
    end else if (v < 6'd52) begin
      r = 8'h61 + {2'b00, v - 6'd26};
    end else if (v < 6'd62) begin
      r = 8'h30 + {2'b00, v - 6'd52};
    end else if (v == 6'd62) begin
      r = 8'h2b;
    end else begin
      r = 8'h2f;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

[sv/b64_front.sv]
// Front end: accepts message bytes, gathers them into groups of three and tracks line position.
// Depends on b64_pkg; pushes complete or padded groups into the group queue.
`default_nettype none

module b64_front (
  input  wire                       clk,
  input  wire                       rst,
  input  wire                       cfg_wr_en,
  input  wire                       cfg_wr_data,
  input  wire                       s_tvalid,
  output logic                      s_tready,
  input  wire  [7:0]                s_tdata,
  input  wire                       s_tlast,
  input  wire                       q_full,
  output logic                      q_push,
  output b64_pkg::b64_group_t       q_data
);
  import b64_pkg::*;

  logic                 add_line_breaks;
  logic [2*ByteW-1:0]   held_bytes;
  logic [1:0]           bytes_in_group;
  logic [GroupCntW-1:0] groups_on_line;
  logic                 any_group_sent;

  logic                 accept;
  logic                 group_done;
  logic [1:0]           cnt;
  logic [GroupCntW-1:0] groups_on_line_next;

  // A byte is taken only when the queue has room for a group it might finish.
  assign s_tready = !q_full;
  assign accept   = s_tvalid && s_tready;

  // A count of three never occurs; treat it as an empty group.
  assign cnt        = (bytes_in_group == 2'd3) ? 2'd0 : bytes_in_group;
  assign group_done = s_tlast || (cnt == 2'd2);
  assign q_push     = accept && group_done;

  // Assemble the outgoing group with zero fill for missing bytes.
  always_comb begin
    q_data.nbytes  = cnt + 2'd1;
    q_data.newline = add_line_breaks && any_group_sent && (groups_on_line == '0);
    q_data.last    = s_tlast;
    case (cnt)
      2'd0:    q_data.bytes = {s_tdata, {2*ByteW{1'b0}}};
      2'd1:    q_data.bytes = {held_bytes[2*ByteW-1:ByteW], s_tdata, {ByteW{1'b0}}};
      default: q_data.bytes = {held_bytes, s_tdata};
    endcase
  end

  // Line position wraps after a full line of groups.
  assign groups_on_line_next = (groups_on_line == GroupCntW'(GroupsPerLine - 1)) ?
                               '0 : groups_on_line + 1'b1;

  // Configuration register.
  always_ff @(posedge clk) begin
    if (rst) begin
      add_line_breaks <= 1'b0;
    end else if (cfg_wr_en) begin
      add_line_breaks <= cfg_wr_data;
    end
  end

  // Group and line state.
  always_ff @(posedge clk) begin
    if (rst) begin
      held_bytes     <= '0;
      bytes_in_group <= '0;
      groups_on_line <= '0;
      any_group_sent <= 1'b0;
    end else if (accept) begin
      if (!group_done) begin
        if (cnt == 2'd0) begin
          held_bytes <= {s_tdata, {ByteW{1'b0}}};
        end else begin
          held_bytes <= {held_bytes[2*ByteW-1:ByteW], s_tdata};
        end
        bytes_in_group <= cnt + 2'd1;
      end else if (s_tlast) begin
        held_bytes     <= '0;
        bytes_in_group <= '0;
        groups_on_line <= '0;
        any_group_sent <= 1'b0;
      end else begin
        held_bytes     <= '0;
        bytes_in_group <= '0;
        groups_on_line <= groups_on_line_next;
        any_group_sent <= 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

[sv/b64_queue.sv]
// Short first-in first-out queue of groups between the front and the back.
// Depends on b64_pkg for the group type.
`default_nettype none

module b64_queue #(
  parameter int unsigned DEPTH = b64_pkg::QueueDepthDef
) (
  input  wire                  clk,
  input  wire                  rst,
  input  wire                  push,
  input  b64_pkg::b64_group_t  push_data,
  input  wire                  pop,
  output b64_pkg::b64_group_t  pop_data,
  output logic                 full,
  output logic                 empty
);
  import b64_pkg::*;

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);

  b64_group_t        entries [DEPTH];
  logic [PtrW-1:0]   wr_ptr;
  logic [PtrW-1:0]   rd_ptr;
  logic [CntW-1:0]   count;
  logic              do_push;
  logic              do_pop;

  assign full     = (count == CntW'(DEPTH));
  assign empty    = (count == '0);
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign pop_data = entries[rd_ptr];

  // Entry storage.
  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PtrW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PtrW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({do_push, do_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

`default_nettype wire

[sv/b64_back.sv]
// Back end: takes groups from the queue and sends their characters one per transaction.
// Depends on b64_pkg for the group type, the alphabet and the fixed characters.
`default_nettype none

module b64_back (
  input  wire                  clk,
  input  wire                  rst,
  input  wire                  q_empty,
  input  b64_pkg::b64_group_t  q_data,
  output logic                 q_pop,
  output logic                 m_tvalid,
  input  wire                  m_tready,
  output logic [7:0]           m_tdata,
  output logic                 m_tuser,
  output logic                 m_tlast
);
  import b64_pkg::*;

  b64_group_t       cur;
  logic             cur_valid;
  b64_pos_t         pos;

  logic             advance;
  logic             emit;
  logic             final_char;
  logic [ByteW-1:0] char_sel;
  logic [ByteW-1:0] b0, b1, b2;

  // The output register frees up when empty or when its transaction completes.
  assign advance    = !m_tvalid || m_tready;
  assign emit       = advance && cur_valid;
  assign final_char = (pos == POS_C3);
  assign q_pop      = !q_empty && (!cur_valid || (emit && final_char));

  assign b0 = cur.bytes[3*ByteW-1:2*ByteW];
  assign b1 = cur.bytes[2*ByteW-1:ByteW];
  assign b2 = cur.bytes[ByteW-1:0];

  // Character at the current position, with padding for short groups.
  always_comb begin
    unique case (pos)
      POS_NEWLINE: char_sel = CharNewline;
      POS_C0:      char_sel = b64_symbol(b0[7:2]);
      POS_C1:      char_sel = b64_symbol({b0[1:0], b1[7:4]});
      POS_C2:      char_sel = (cur.nbytes == 2'd1) ? CharPad :
                              b64_symbol({b1[3:0], b2[7:6]});
      POS_C3:      char_sel = (cur.nbytes == 2'd3) ? b64_symbol(b2[5:0]) : CharPad;
      default:     char_sel = CharPad;
    endcase
  end

  // Current group and position within it.
  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid <= 1'b0;
      pos       <= POS_NEWLINE;
    end else if (q_pop) begin
      cur_valid <= 1'b1;
      cur       <= q_data;
      pos       <= q_data.newline ? POS_NEWLINE : POS_C0;
    end else if (emit) begin
      if (final_char) begin
        cur_valid <= 1'b0;
      end else begin
        pos <= b64_pos_t'(pos + 3'd1);
      end
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance) begin
      m_tvalid <= cur_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      m_tdata <= char_sel;
      m_tuser <= final_char;
      m_tlast <= final_char && cur.last;
    end
  end

endmodule

`default_nettype wire

[sv/base64_stream_encoder_unit.sv]
// Top level of the streaming base64 encoder: front end, group queue and character back end.
// Depends on b64_pkg, b64_front, b64_queue and b64_back.
`default_nettype none

// Encodes a byte stream into standard base64 text with padding. Bytes arrive on the slave
// side with tlast on the final byte of a message; every third byte, or the final byte,
// completes a group whose four characters leave on the master side, one character per
// transaction, tuser set on the last character a byte caused and tlast on the final
// character of the message. With cfg_wr_data written to 1, a line feed precedes each group
// that starts after a nonzero multiple of 76 characters. The master side sends at most one
// character per cycle, so the character serializer sets the rate: a byte that only joins a
// group is taken whenever the queue has room, and sustained input runs at three bytes per
// four or five output characters. A queue of QUEUE_DEPTH groups lets the input keep going
// while the output stalls; input stalls only when that queue is full.
module base64_stream_encoder_unit #(
  parameter int unsigned QUEUE_DEPTH = b64_pkg::QueueDepthDef
) (
  input  wire        clk,
  input  wire        rst,
  input  wire        cfg_wr_en,
  input  wire        cfg_wr_data,   // add_line_breaks
  input  wire        s_tvalid,
  output logic       s_tready,
  input  wire  [7:0] s_tdata,       // [7:0] data_byte
  input  wire        s_tlast,       // last_byte
  output logic       m_tvalid,
  input  wire        m_tready,
  output logic [7:0] m_tdata,       // [7:0] out_char
  output logic       m_tuser,       // [0] last_in_run
  output logic       m_tlast        // end_of_message
);
  import b64_pkg::*;

  b64_group_t push_data;
  b64_group_t pop_data;
  logic       push;
  logic       pop;
  logic       full;
  logic       empty;

  // Byte intake and grouping.
  b64_front u_front (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .s_tvalid    (s_tvalid),
    .s_tready    (s_tready),
    .s_tdata     (s_tdata),
    .s_tlast     (s_tlast),
    .q_full      (full),
    .q_push      (push),
    .q_data      (push_data)
  );

  // Group queue.
  b64_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .pop_data  (pop_data),
    .full      (full),
    .empty     (empty)
  );

  // Character serializer.
  b64_back u_back (
    .clk      (clk),
    .rst      (rst),
    .q_empty  (empty),
    .q_data   (pop_data),
    .q_pop    (pop),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

endmodule

`default_nettype wire
